// ===== sv/rdh_pkg.sv =====
// shared types, constants and codes of the radial distribution histogram
package rdh_pkg;

   localparam int MAX_PARTICLES = 4096;
   localparam int NUM_BINS      = 128;
   localparam int POS_AW        = $clog2(MAX_PARTICLES);
   localparam int BIN_AW        = $clog2(NUM_BINS);
   localparam int COUNT_W       = 13;
   localparam int CSR_AW        = 3;

   localparam logic [47:0] BIN_MAX = 48'hFFFF_FFFF_FFFF;
   localparam logic [15:0] FRAMES_MAX = 16'hFFFF;

   // register indexes
   localparam logic [CSR_AW-1:0] CSR_BOX_X          = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_BOX_Y          = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_BOX_Z          = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_CUTOFF         = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_BIN_SCALE      = 3'd4;
   localparam logic [CSR_AW-1:0] CSR_BINS_IN_USE    = 3'd5;
   localparam logic [CSR_AW-1:0] CSR_PARTICLE_COUNT = 3'd6;

   // request and result codes
   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_READ   = 1'b1;
   localparam logic KIND_FRAME = 1'b0;
   localparam logic KIND_BIN   = 1'b1;

   typedef struct packed {
      logic               req_type;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [6:0]         bin_index;
   } req_word_type;

   typedef struct packed {
      logic        result_kind;
      logic [47:0] bin_count;
      logic [15:0] frames_done;
   } rsp_word_type;

   typedef struct packed {
      logic [2:0][30:0]   box;
      logic [30:0]        cutoff;
      logic [31:0]        bin_scale;
      logic [BIN_AW-1:0]  last_bin;
   } geom_type;

   typedef struct packed {
      logic             start;
      logic [2:0][31:0] a_pos;
      logic [2:0][31:0] b_pos;
   } dist_cmd_type;

   typedef struct packed {
      logic              done;
      logic              hit;
      logic [BIN_AW-1:0] bin;
   } dist_stat_type;

   typedef enum logic [3:0] {
      D_IDLE, D_DIFF, D_WRAP, D_ABS, D_SQ, D_ACC, D_ROOT_GO, D_ROOT, D_CHK, D_BIN
   } dist_state_type;

   typedef enum logic [3:0] {
      T_IDLE, T_BIN_RD, T_FETCH_I, T_LATCH_I, T_FETCH_J, T_LATCH_J, T_DIST,
      T_HRD, T_HWR, T_NEXT, T_DONE
   } top_state_type;

endpackage

// ===== sv/rdh_ram.sv =====
// generic single-port ram with registered read
module rdh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/rdh_isqrt.sv =====
// iterative integer square root, one root bit per cycle over 32 steps
module rdh_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] value,
   output logic        done,
   output logic [31:0] root
);

   logic [63:0] v_ff, v_in;
   logic [63:0] res_ff, res_in;
   logic [63:0] bit_ff, bit_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [63:0] trial;

   always_comb begin
      v_in    = v_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = res_ff + bit_ff;
      if (start) begin
         v_in    = value;
         res_in  = '0;
         bit_in  = 64'd1 << 62;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (v_ff >= trial) begin
            v_in   = v_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff == 64'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      v_ff   <= v_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = res_ff[31:0];

endmodule

// ===== sv/rdh_pair_dist.sv =====
// pair distance and bin unit: one axis per pass, shared square and root
module rdh_pair_dist (
   input  logic                   clock,
   input  logic                   reset,
   input  rdh_pkg::dist_cmd_type  cmd,
   input  rdh_pkg::geom_type      geom,
   output rdh_pkg::dist_stat_type stat
);

   rdh_pkg::dist_state_type state_ff, state_in;
   logic [2:0][31:0]        a_ff, a_in, b_ff, b_in;
   logic [1:0]              axis_ff, axis_in;
   logic signed [33:0]      d_ff, d_in;
   logic [30:0]             m_ff, m_in;
   logic [61:0]             sq_ff, sq_in;
   logic [63:0]             acc_ff, acc_in;
   logic [62:0]             prod_ff, prod_in;
   rdh_pkg::dist_stat_type  stat_ff, stat_in;
   logic                    root_go;
   logic                    root_done;
   logic [31:0]             root;
   logic signed [33:0]      twice, boxs;
   logic [33:0]             mag;
   logic [30:0]             bin_raw;

   rdh_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (root_go),
      .value (acc_ff),
      .done  (root_done),
      .root  (root)
   );

   always_comb begin
      state_in = state_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      axis_in  = axis_ff;
      d_in     = d_ff;
      m_in     = m_ff;
      sq_in    = sq_ff;
      acc_in   = acc_ff;
      prod_in  = prod_ff;
      stat_in  = stat_ff;
      stat_in.done = 1'b0;
      root_go  = 1'b0;
      twice    = {d_ff[32:0], 1'b0};
      boxs     = $signed({3'b000, geom.box[axis_ff]});
      mag      = d_ff[33] ? 34'(-d_ff) : 34'(d_ff);
      bin_raw  = prod_ff[62:32];
      case (state_ff)
         rdh_pkg::D_IDLE: begin
            if (cmd.start) begin
               a_in     = cmd.a_pos;
               b_in     = cmd.b_pos;
               axis_in  = 2'd0;
               acc_in   = '0;
               state_in = rdh_pkg::D_DIFF;
            end
         end
         rdh_pkg::D_DIFF: begin
            d_in = $signed({{2{a_ff[axis_ff][31]}}, a_ff[axis_ff]})
                 - $signed({{2{b_ff[axis_ff][31]}}, b_ff[axis_ff]});
            state_in = rdh_pkg::D_WRAP;
         end
         rdh_pkg::D_WRAP: begin
            if (twice >= boxs) begin
               d_in = d_ff - boxs;
            end else if (twice < -boxs) begin
               d_in = d_ff + boxs;
            end
            state_in = rdh_pkg::D_ABS;
         end
         rdh_pkg::D_ABS: begin
            if (mag >= {3'b000, geom.cutoff}) begin
               stat_in.done = 1'b1;
               stat_in.hit  = 1'b0;
               state_in     = rdh_pkg::D_IDLE;
            end else begin
               m_in     = mag[30:0];
               state_in = rdh_pkg::D_SQ;
            end
         end
         rdh_pkg::D_SQ: begin
            sq_in    = m_ff * m_ff;
            state_in = rdh_pkg::D_ACC;
         end
         rdh_pkg::D_ACC: begin
            acc_in = acc_ff + {2'b00, sq_ff};
            if (axis_ff == 2'd2) begin
               state_in = rdh_pkg::D_ROOT_GO;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = rdh_pkg::D_DIFF;
            end
         end
         rdh_pkg::D_ROOT_GO: begin
            root_go  = 1'b1;
            state_in = rdh_pkg::D_ROOT;
         end
         rdh_pkg::D_ROOT: begin
            if (root_done) begin
               state_in = rdh_pkg::D_CHK;
            end
         end
         rdh_pkg::D_CHK: begin
            if (root >= {1'b0, geom.cutoff}) begin
               stat_in.done = 1'b1;
               stat_in.hit  = 1'b0;
               state_in     = rdh_pkg::D_IDLE;
            end else begin
               prod_in  = root[30:0] * geom.bin_scale;
               state_in = rdh_pkg::D_BIN;
            end
         end
         rdh_pkg::D_BIN: begin
            stat_in.done = 1'b1;
            stat_in.hit  = 1'b1;
            if (bin_raw > {24'd0, geom.last_bin}) begin
               stat_in.bin = geom.last_bin;
            end else begin
               stat_in.bin = bin_raw[rdh_pkg::BIN_AW-1:0];
            end
            state_in = rdh_pkg::D_IDLE;
         end
         default: begin
            state_in = rdh_pkg::D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rdh_pkg::D_IDLE;
         stat_ff.done <= 1'b0;
      end else begin
         state_ff     <= state_in;
         stat_ff.done <= stat_in.done;
      end
      stat_ff.hit <= stat_in.hit;
      stat_ff.bin <= stat_in.bin;
      a_ff    <= a_in;
      b_ff    <= b_in;
      axis_ff <= axis_in;
      d_ff    <= d_in;
      m_ff    <= m_in;
      sq_ff   <= sq_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
   end

   assign stat = stat_ff;

endmodule

// ===== sv/radial_distribution_histogram.sv =====
// top level: position store, pair sequencer, histogram and register file
//
// channel   ports                         direction  notes
// request   start, busy, req_word          in         taken when start and not busy
// response  rsp_strobe, rsp_word           out        one cycle per word, never held
// csr       csr_valid/ready/index/data     in         ready always high
//
// a position load is written in the cycle it is taken; a bin read word passes the
// histogram ram read register, then the response register; the frame-closing load
// runs the pair pass over all n*(n-1)/2 pairs: per pair 3 axis passes, the root,
// bin multiply and histogram update, cut short once an axis or root reaches cutoff
// synchronous reset clears control, the bin valid bits and the frame counter;
// the histogram ram itself needs no clearing pass
module radial_distribution_histogram (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  rdh_pkg::req_word_type         req_word,
   output logic                          rsp_strobe,
   output rdh_pkg::rsp_word_type         rsp_word,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rdh_pkg::CSR_AW-1:0]    csr_index,
   input  logic [31:0]                   csr_data
);

   // configuration registers
   logic [30:0] box_x_ff, box_y_ff, box_z_ff, cutoff_ff;
   logic [31:0] bin_scale_ff;
   logic [7:0]  bins_in_use_ff;
   logic [12:0] particle_count_ff;

   rdh_pkg::top_state_type state_ff, state_in;
   logic [rdh_pkg::COUNT_W-1:0] load_pos_ff, load_pos_in;
   logic [rdh_pkg::POS_AW-1:0]  i_ff, i_in, j_ff, j_in;
   logic [15:0]                 frames_ff, frames_in;
   logic [95:0]                 a_ff, a_in;
   logic [rdh_pkg::BIN_AW-1:0]  bin_ff, bin_in;
   logic [rdh_pkg::NUM_BINS-1:0] hvalid_ff, hvalid_in;
   logic                        hvalid_q_ff;
   logic                        rsp_strobe_ff, rsp_strobe_in;
   rdh_pkg::rsp_word_type       rsp_word_ff, rsp_word_in;

   // position store and histogram ram ports
   logic                        pos_we;
   logic [rdh_pkg::POS_AW-1:0]  pos_addr;
   logic [95:0]                 pos_wdata, pos_q;
   logic                        hist_we;
   logic [rdh_pkg::BIN_AW-1:0]  hist_addr;
   logic [47:0]                 hist_wdata, hist_q, hist_cur;

   rdh_pkg::geom_type           geom;
   rdh_pkg::dist_cmd_type       cmd;
   rdh_pkg::dist_stat_type      stat;

   logic [rdh_pkg::COUNT_W-1:0] count_eff;
   logic [rdh_pkg::POS_AW-1:0]  slot;
   logic [rdh_pkg::COUNT_W-1:0] slot_next;

   // effective frame size and last bin
   always_comb begin
      if (particle_count_ff < 13'd2) begin
         count_eff = 13'd2;
      end else if (particle_count_ff > 13'(rdh_pkg::MAX_PARTICLES)) begin
         count_eff = 13'(rdh_pkg::MAX_PARTICLES);
      end else begin
         count_eff = particle_count_ff;
      end
      geom.box[0]    = box_x_ff;
      geom.box[1]    = box_y_ff;
      geom.box[2]    = box_z_ff;
      geom.cutoff    = cutoff_ff;
      geom.bin_scale = bin_scale_ff;
      if (bins_in_use_ff == 8'd0) begin
         geom.last_bin = '0;
      end else if (bins_in_use_ff > 8'(rdh_pkg::NUM_BINS)) begin
         geom.last_bin = rdh_pkg::BIN_AW'(rdh_pkg::NUM_BINS - 1);
      end else begin
         geom.last_bin = rdh_pkg::BIN_AW'(bins_in_use_ff - 8'd1);
      end
   end

   // load slot, clamped to the last entry
   assign slot = (load_pos_ff >= 13'(rdh_pkg::MAX_PARTICLES))
               ? rdh_pkg::POS_AW'(rdh_pkg::MAX_PARTICLES - 1)
               : load_pos_ff[rdh_pkg::POS_AW-1:0];
   assign slot_next = {1'b0, slot} + 13'd1;

   rdh_ram #(.WIDTH(96), .DEPTH(rdh_pkg::MAX_PARTICLES)) u_pos_ram (
      .clock (clock),
      .we    (pos_we),
      .addr  (pos_addr),
      .wdata (pos_wdata),
      .rdata (pos_q)
   );

   rdh_ram #(.WIDTH(48), .DEPTH(rdh_pkg::NUM_BINS)) u_hist_ram (
      .clock (clock),
      .we    (hist_we),
      .addr  (hist_addr),
      .wdata (hist_wdata),
      .rdata (hist_q)
   );

   rdh_pair_dist u_pair_dist (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .geom  (geom),
      .stat  (stat)
   );

   // a never-written bin reads as zero
   assign hist_cur = hvalid_q_ff ? hist_q : 48'd0;

   // x in the low lane so that lane k lines up with box k
   assign pos_wdata = {req_word.pos_z, req_word.pos_y, req_word.pos_x};

   always_comb begin
      state_in      = state_ff;
      load_pos_in   = load_pos_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      frames_in     = frames_ff;
      a_in          = a_ff;
      bin_in        = bin_ff;
      hvalid_in     = hvalid_ff;
      rsp_strobe_in = 1'b0;
      rsp_word_in   = rsp_word_ff;
      pos_we        = 1'b0;
      pos_addr      = slot;
      hist_we       = 1'b0;
      hist_addr     = req_word.bin_index;
      hist_wdata    = (hist_cur == rdh_pkg::BIN_MAX) ? hist_cur : hist_cur + 48'd1;
      cmd.start     = 1'b0;
      cmd.a_pos     = {a_ff[95:64], a_ff[63:32], a_ff[31:0]};
      cmd.b_pos     = {pos_q[95:64], pos_q[63:32], pos_q[31:0]};
      case (state_ff)
         rdh_pkg::T_IDLE: begin
            if (start) begin
               if (req_word.req_type == rdh_pkg::REQ_READ) begin
                  state_in = rdh_pkg::T_BIN_RD;
               end else begin
                  pos_we = 1'b1;
                  if (slot_next >= count_eff) begin
                     // frame complete: start the pair pass
                     load_pos_in = '0;
                     i_in        = '0;
                     j_in        = rdh_pkg::POS_AW'(1);
                     state_in    = rdh_pkg::T_FETCH_I;
                  end else begin
                     load_pos_in = slot_next;
                  end
               end
            end
         end
         rdh_pkg::T_BIN_RD: begin
            rsp_strobe_in           = 1'b1;
            rsp_word_in.result_kind = rdh_pkg::KIND_BIN;
            rsp_word_in.bin_count   = hist_cur;
            rsp_word_in.frames_done = frames_ff;
            state_in                = rdh_pkg::T_IDLE;
         end
         rdh_pkg::T_FETCH_I: begin
            pos_addr = i_ff;
            state_in = rdh_pkg::T_LATCH_I;
         end
         rdh_pkg::T_LATCH_I: begin
            a_in     = pos_q;
            pos_addr = j_ff;
            state_in = rdh_pkg::T_LATCH_J;
         end
         rdh_pkg::T_FETCH_J: begin
            pos_addr = j_ff;
            state_in = rdh_pkg::T_LATCH_J;
         end
         rdh_pkg::T_LATCH_J: begin
            cmd.start = 1'b1;
            state_in  = rdh_pkg::T_DIST;
         end
         rdh_pkg::T_DIST: begin
            if (stat.done) begin
               bin_in   = stat.bin;
               state_in = stat.hit ? rdh_pkg::T_HRD : rdh_pkg::T_NEXT;
            end
         end
         rdh_pkg::T_HRD: begin
            hist_addr = bin_ff;
            state_in  = rdh_pkg::T_HWR;
         end
         rdh_pkg::T_HWR: begin
            // saturating read-modify-write of the bin
            hist_addr         = bin_ff;
            hist_we           = 1'b1;
            hvalid_in[bin_ff] = 1'b1;
            state_in          = rdh_pkg::T_NEXT;
         end
         rdh_pkg::T_NEXT: begin
            if ({1'b0, j_ff} + 13'd1 < count_eff) begin
               j_in     = j_ff + rdh_pkg::POS_AW'(1);
               state_in = rdh_pkg::T_FETCH_J;
            end else if ({1'b0, i_ff} + 13'd2 < count_eff) begin
               i_in     = i_ff + rdh_pkg::POS_AW'(1);
               j_in     = i_ff + rdh_pkg::POS_AW'(2);
               state_in = rdh_pkg::T_FETCH_I;
            end else begin
               state_in = rdh_pkg::T_DONE;
            end
         end
         rdh_pkg::T_DONE: begin
            frames_in = (frames_ff == rdh_pkg::FRAMES_MAX) ? frames_ff : frames_ff + 16'd1;
            rsp_strobe_in           = 1'b1;
            rsp_word_in.result_kind = rdh_pkg::KIND_FRAME;
            rsp_word_in.bin_count   = '0;
            rsp_word_in.frames_done = frames_in;
            state_in                = rdh_pkg::T_IDLE;
         end
         default: begin
            state_in = rdh_pkg::T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rdh_pkg::T_IDLE;
         load_pos_ff   <= '0;
         frames_ff     <= '0;
         hvalid_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         load_pos_ff   <= load_pos_in;
         frames_ff     <= frames_in;
         hvalid_ff     <= hvalid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      hvalid_q_ff <= hvalid_ff[hist_addr];
      i_ff        <= i_in;
      j_ff        <= j_in;
      a_ff        <= a_in;
      bin_ff      <= bin_in;
      rsp_word_ff <= rsp_word_in;
   end

   // register file, one word per csr handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         box_x_ff          <= 31'd65536;
         box_y_ff          <= 31'd65536;
         box_z_ff          <= 31'd65536;
         cutoff_ff         <= 31'd327680;
         bin_scale_ff      <= 32'd1310720;
         bins_in_use_ff    <= 8'd100;
         particle_count_ff <= 13'd2;
      end else if (csr_valid) begin
         case (csr_index)
            rdh_pkg::CSR_BOX_X:          box_x_ff          <= csr_data[30:0];
            rdh_pkg::CSR_BOX_Y:          box_y_ff          <= csr_data[30:0];
            rdh_pkg::CSR_BOX_Z:          box_z_ff          <= csr_data[30:0];
            rdh_pkg::CSR_CUTOFF:         cutoff_ff         <= csr_data[30:0];
            rdh_pkg::CSR_BIN_SCALE:      bin_scale_ff      <= csr_data;
            rdh_pkg::CSR_BINS_IN_USE:    bins_in_use_ff    <= csr_data[7:0];
            rdh_pkg::CSR_PARTICLE_COUNT: particle_count_ff <= csr_data[12:0];
            default: begin
            end
         endcase
      end
   end

   assign busy       = (state_ff != rdh_pkg::T_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

endmodule

// ===== dv/testbench.sv =====
// self-checking testbench for the radial distribution histogram
module testbench;

   // clock, reset and dut ports
   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   rdh_pkg::req_word_type req_word = '0;
   logic         rsp_strobe;
   rdh_pkg::rsp_word_type rsp_word;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [rdh_pkg::CSR_AW-1:0] csr_index = '0;
   logic [31:0]  csr_data = '0;

   always #2 clock = ~clock;

   radial_distribution_histogram dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_word(req_word),
      .rsp_strobe(rsp_strobe), .rsp_word(rsp_word), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_data(csr_data)
   );

   // shadow copy of the block: registers, position store, histogram, counters
   logic [30:0] sh_box [3];
   logic [30:0] sh_cutoff;
   logic [31:0] sh_scale;
   logic [7:0]  sh_bins;
   logic [12:0] sh_count;
   logic signed [31:0] sh_pos [3][rdh_pkg::MAX_PARTICLES];
   logic [47:0] sh_hist [rdh_pkg::NUM_BINS];
   int unsigned sh_load_slot;
   logic [15:0] sh_frames;

   rdh_pkg::rsp_word_type pending_words [$];
   int errors = 0;
   int words_checked = 0;
   int frames_seen = 0;
   int items_sent = 0;
   int gap_pct = 0;

   // integer square root, truncated
   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res = 0;
      longint unsigned bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // distance of one pair under minimum image, then bin it if inside the cutoff
   function automatic void bin_pair(int a, int b, int unsigned last);
      longint d;
      longint bx;
      longint unsigned m;
      longint unsigned d2 = 0;
      longint unsigned r;
      longint unsigned bin;
      for (int k = 0; k < 3; k++) begin
         d  = longint'(sh_pos[k][a]) - longint'(sh_pos[k][b]);
         bx = longint'({33'd0, sh_box[k]});
         if (2 * d >= bx) d -= bx;
         else if (2 * d < -bx) d += bx;
         m = (d < 0) ? -d : d;
         if (m >= {33'd0, sh_cutoff}) return;
         d2 += m * m;
      end
      r = int_sqrt(d2);
      if (r >= {33'd0, sh_cutoff}) return;
      bin = (r * {32'd0, sh_scale}) >> 32;
      if (bin > last) bin = last;
      if (sh_hist[bin] != rdh_pkg::BIN_MAX) sh_hist[bin] = sh_hist[bin] + 1;
   endfunction

   // expected word for one accepted request, if any
   function automatic void predict_request(rdh_pkg::req_word_type w);
      rdh_pkg::rsp_word_type exp_w;
      int unsigned n;
      int unsigned nb;
      if (w.req_type == rdh_pkg::REQ_READ) begin
         exp_w.result_kind = rdh_pkg::KIND_BIN;
         exp_w.bin_count   = sh_hist[w.bin_index];
         exp_w.frames_done = sh_frames;
         pending_words.push_back(exp_w);
         return;
      end
      n = (sh_count < 2) ? 2 : (sh_count > rdh_pkg::MAX_PARTICLES) ? rdh_pkg::MAX_PARTICLES
                                                                     : sh_count;
      if (sh_load_slot >= rdh_pkg::MAX_PARTICLES) sh_load_slot = rdh_pkg::MAX_PARTICLES - 1;
      sh_pos[0][sh_load_slot] = w.pos_x;
      sh_pos[1][sh_load_slot] = w.pos_y;
      sh_pos[2][sh_load_slot] = w.pos_z;
      sh_load_slot++;
      if (sh_load_slot < n) return;
      nb = (sh_bins == 0) ? 1 : (sh_bins > rdh_pkg::NUM_BINS) ? rdh_pkg::NUM_BINS : sh_bins;
      for (int i = 0; i + 1 < n; i++)
         for (int j = i + 1; j < n; j++)
            bin_pair(i, j, nb - 1);
      if (sh_frames != rdh_pkg::FRAMES_MAX) sh_frames++;
      sh_load_slot = 0;
      exp_w.result_kind = rdh_pkg::KIND_FRAME;
      exp_w.bin_count   = '0;
      exp_w.frames_done = sh_frames;
      pending_words.push_back(exp_w);
   endfunction

   // response checker: every strobe must match the oldest expected word
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_words.size() == 0) begin
            $error("unexpected response word %h", rsp_word);
            errors++;
         end else begin
            automatic rdh_pkg::rsp_word_type e = pending_words.pop_front();
            if (rsp_word.result_kind !== e.result_kind) begin
               $error("result_kind expected %0d got %0d", e.result_kind, rsp_word.result_kind);
               errors++;
            end
            if (rsp_word.bin_count !== e.bin_count) begin
               $error("bin_count expected %0d got %0d", e.bin_count, rsp_word.bin_count);
               errors++;
            end
            if (rsp_word.frames_done !== e.frames_done) begin
               $error("frames_done expected %0d got %0d", e.frames_done, rsp_word.frames_done);
               errors++;
            end
            if (e.result_kind == rdh_pkg::KIND_FRAME) frames_seen++;
            words_checked++;
         end
      end
   end

   // send one request word; called at a falling edge, returns at a falling edge
   task automatic send_word(rdh_pkg::req_word_type w);
      req_word = w;
      start    = 1'b1;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      predict_request(w);
      items_sent++;
      @(negedge clock);
      if ($urandom_range(99) < gap_pct) begin
         start = 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
   endtask

   task automatic load_pos(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      rdh_pkg::req_word_type w;
      w = '0;
      w.req_type = rdh_pkg::REQ_LOAD;
      w.pos_x = x; w.pos_y = y; w.pos_z = z;
      w.bin_index = 7'($urandom);
      send_word(w);
   endtask

   task automatic read_bin(logic [6:0] idx);
      rdh_pkg::req_word_type w;
      w = '0;
      w.req_type  = rdh_pkg::REQ_READ;
      w.bin_index = idx;
      w.pos_x = $urandom; w.pos_y = $urandom; w.pos_z = $urandom;
      send_word(w);
   endtask

   // wait until every word is back and the block is quiet, then let it settle
   task automatic drain;
      start = 1'b0;
      while (pending_words.size() != 0 || busy) @(posedge clock);
      repeat (10) @(negedge clock);
   endtask

   // register write, only ever issued while the block is idle
   task automatic write_csr(logic [rdh_pkg::CSR_AW-1:0] idx, logic [31:0] val);
      csr_index = idx;
      csr_data  = val;
      csr_valid = 1'b1;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      case (idx)
         rdh_pkg::CSR_BOX_X:          sh_box[0] = val[30:0];
         rdh_pkg::CSR_BOX_Y:          sh_box[1] = val[30:0];
         rdh_pkg::CSR_BOX_Z:          sh_box[2] = val[30:0];
         rdh_pkg::CSR_CUTOFF:         sh_cutoff = val[30:0];
         rdh_pkg::CSR_BIN_SCALE:      sh_scale  = val;
         rdh_pkg::CSR_BINS_IN_USE:    sh_bins   = val[7:0];
         rdh_pkg::CSR_PARTICLE_COUNT: sh_count  = val[12:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_geometry(logic [31:0] bx, logic [31:0] by, logic [31:0] bz,
                               logic [31:0] cut, logic [31:0] scale, logic [31:0] nbins);
      write_csr(rdh_pkg::CSR_BOX_X, bx);
      write_csr(rdh_pkg::CSR_BOX_Y, by);
      write_csr(rdh_pkg::CSR_BOX_Z, bz);
      write_csr(rdh_pkg::CSR_CUTOFF, cut);
      write_csr(rdh_pkg::CSR_BIN_SCALE, scale);
      write_csr(rdh_pkg::CSR_BINS_IN_USE, nbins);
   endtask

   // reset values: one frame of two particles, read a few bins
   task automatic test_reset_defaults;
      load_pos(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      load_pos(32'h0000_4000, 32'h0000_2000, 32'h0000_1000);
      read_bin(7'd0);
      read_bin(7'd5);
      read_bin(7'd127);
      drain();
   endtask

   // position extremes with the widest box, largest scale and all bins
   task automatic test_extreme_positions;
      set_geometry(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd128);
      write_csr(rdh_pkg::CSR_PARTICLE_COUNT, 32'd4);
      load_pos(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      load_pos(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      load_pos(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001);
      load_pos(32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000);
      read_bin(7'd127);
      drain();
   endtask

   // zero box, zero cutoff, zero scale, bins in use out of range, count below two
   task automatic test_special_registers;
      set_geometry(32'd0, 32'd0, 32'd0, 32'h0005_0000, 32'h0001_0000, 32'd0);
      write_csr(rdh_pkg::CSR_PARTICLE_COUNT, 32'd0);
      load_pos(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      load_pos(32'h0003_0000, 32'h0000_8000, 32'hFFFF_0000);
      drain();
      write_csr(rdh_pkg::CSR_CUTOFF, 32'd0);
      load_pos(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      load_pos(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      drain();
      set_geometry(32'h0004_0000, 32'h0004_0000, 32'h0004_0000,
                   32'h0004_0000, 32'd0, 32'd255);
      write_csr(rdh_pkg::CSR_PARTICLE_COUNT, 32'd1);
      load_pos(32'h0000_1000, 32'h0003_0000, 32'h0000_0000);
      load_pos(32'h0001_0000, 32'h0000_0000, 32'h0001_8000);
      read_bin(7'd0);
      drain();
   endtask

   // count far above the maximum, then lowered mid-frame so the next load closes it
   task automatic test_count_lowered;
      set_geometry(32'h000A_0000, 32'h000A_0000, 32'h000A_0000,
                   32'h0005_0000, 32'h0014_0000, 32'd100);
      write_csr(rdh_pkg::CSR_PARTICLE_COUNT, 32'h1FFF);
      load_pos(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
      load_pos(32'h0009_0000, 32'h0001_0000, 32'h0000_8000);
      load_pos(32'h0004_0000, 32'h0004_0000, 32'h0004_0000);
      drain();
      write_csr(rdh_pkg::CSR_PARTICLE_COUNT, 32'd2);
      load_pos(32'h0002_0000, 32'h0002_0000, 32'h0002_0000);
      for (int b = 0; b < 6; b++) read_bin(7'(b));
      drain();
   endtask

   // random frames under random geometry, through each idling pattern
   task automatic test_random_frames;
      int pcts [4] = '{0, 48, 0, 20};
      logic [31:0] bx;
      logic [31:0] half;
      int n;
      for (int ph = 0; ph < 4; ph++) begin
         gap_pct = pcts[ph];
         for (int f = 0; f < 4; f++) begin
            bx = $urandom_range(32'h0001_0000, 32'h0010_0000);
            half = bx >> 1;
            set_geometry(bx, bx + $urandom_range(0, 32'h8000), bx,
                         $urandom_range(32'h4000, half + 32'h4000),
                         $urandom_range(32'h0001_0000, 32'h0040_0000),
                         $urandom_range(1, 128));
            n = (f == 0) ? $urandom_range(2, 3) : $urandom_range(4, 9);
            write_csr(rdh_pkg::CSR_PARTICLE_COUNT, n);
            for (int fr = 0; fr < 2; fr++) begin
               for (int p = 0; p < n; p++) begin
                  if ($urandom_range(99) < 20) read_bin(7'($urandom));
                  // mostly positions within one period, sometimes anything
                  if ($urandom_range(99) < 10)
                     load_pos($urandom, $urandom, $urandom);
                  else
                     load_pos($urandom_range(0, bx) - half, $urandom_range(0, bx) - half,
                              $urandom_range(0, bx) - half);
               end
            end
            for (int b = 0; b < 3; b++) read_bin(7'($urandom_range(0, 15)));
            drain();
         end
      end
      gap_pct = 0;
   endtask

   initial begin
      for (int k = 0; k < 3; k++) sh_box[k] = 31'd65536;
      sh_cutoff = 31'd327680;
      sh_scale  = 32'd1310720;
      sh_bins   = 8'd100;
      sh_count  = 13'd2;
      sh_load_slot = 0;
      sh_frames = '0;
      foreach (sh_hist[i]) sh_hist[i] = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_defaults();
      test_extreme_positions();
      test_special_registers();
      test_count_lowered();
      test_random_frames();
      drain();
      repeat (100) @(posedge clock);
      $display("sent %0d request words, checked %0d response words", items_sent, words_checked);
      $display("covered %0d frames over varied box, cutoff and bin settings", frames_seen);
      if (errors == 0 && pending_words.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // watchdog
   initial begin
      #4000000;
      $display("FAILURE");
      $finish;
   end

endmodule
